/* hdl/frd_pkg.sv */
// Shared types, control word layout and microcode table of the fraction reducer.
`timescale 1ns / 1ps
`default_nettype none

package frd_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int STEP_W         = 4;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP        = 4'd0,
		OP_LOAD       = 4'd1,
		OP_HALVE_BOTH = 4'd2,
		OP_HALVE_X    = 4'd3,
		OP_HALVE_Y    = 4'd4,
		OP_SUB        = 4'd5,
		OP_SETG       = 4'd6,
		OP_SETG_Y     = 4'd7,
		OP_DIV_INIT   = 4'd8,
		OP_DIV_STEP   = 4'd9,
		OP_NUM_DONE   = 4'd10,
		OP_DEN_DONE   = 4'd11,
		OP_PASS       = 4'd12
	} op_t;

	typedef enum logic [3:0] {
		COND_NEVER     = 4'd0,
		COND_ALWAYS    = 4'd1,
		COND_REQ       = 4'd2,
		COND_DEN_ZERO  = 4'd3,
		COND_NUM_ZERO  = 4'd4,
		COND_BOTH_EVEN = 4'd5,
		COND_X_EVEN    = 4'd6,
		COND_Y_EVEN    = 4'd7,
		COND_X_NE_Y    = 4'd8,
		COND_NOT_LAST  = 4'd9,
		COND_OUT_FREE  = 4'd10
	} cond_t;

	// on a false condition: hold = 1 stays on the step, else falls through
	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  hold;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic both_even;
		logic x_even;
		logic y_even;
		logic x_ne_y;
		logic div_last;
		logic out_full;
	} status_t;

	localparam step_t STEP_IDLE     = 4'd0;
	localparam step_t STEP_CHK_DEN  = 4'd1;
	localparam step_t STEP_CHK_NUM  = 4'd2;
	localparam step_t STEP_TWOS     = 4'd3;
	localparam step_t STEP_ODD_X    = 4'd4;
	localparam step_t STEP_ODD_Y    = 4'd5;
	localparam step_t STEP_SUB      = 4'd6;
	localparam step_t STEP_SETG     = 4'd7;
	localparam step_t STEP_DIVN_IN  = 4'd8;
	localparam step_t STEP_DIVN     = 4'd9;
	localparam step_t STEP_NUM_DONE = 4'd10;
	localparam step_t STEP_DIVD     = 4'd11;
	localparam step_t STEP_DEN_DONE = 4'd12;
	localparam step_t STEP_PASS     = 4'd13;
	localparam step_t STEP_SETG_Y   = 4'd14;
	localparam step_t STEP_LAST     = STEP_SETG_Y;

	function automatic ctrl_word_t frd_rom(input step_t pc);
		ctrl_word_t w;
		w = '{op: OP_NOP, cond: COND_ALWAYS, hold: 1'b0, target: STEP_IDLE};
		case (pc)
			STEP_IDLE:     w = '{OP_LOAD,       COND_REQ,       1'b1, STEP_CHK_DEN};
			STEP_CHK_DEN:  w = '{OP_NOP,        COND_DEN_ZERO,  1'b0, STEP_PASS};
			STEP_CHK_NUM:  w = '{OP_NOP,        COND_NUM_ZERO,  1'b0, STEP_SETG_Y};
			STEP_TWOS:     w = '{OP_HALVE_BOTH, COND_BOTH_EVEN, 1'b0, STEP_TWOS};
			STEP_ODD_X:    w = '{OP_HALVE_X,    COND_X_EVEN,    1'b0, STEP_ODD_X};
			STEP_ODD_Y:    w = '{OP_HALVE_Y,    COND_Y_EVEN,    1'b0, STEP_ODD_Y};
			STEP_SUB:      w = '{OP_SUB,        COND_X_NE_Y,    1'b0, STEP_ODD_Y};
			STEP_SETG:     w = '{OP_SETG,       COND_NEVER,     1'b0, STEP_IDLE};
			STEP_DIVN_IN:  w = '{OP_DIV_INIT,   COND_NEVER,     1'b0, STEP_IDLE};
			STEP_DIVN:     w = '{OP_DIV_STEP,   COND_NOT_LAST,  1'b0, STEP_DIVN};
			STEP_NUM_DONE: w = '{OP_NUM_DONE,   COND_NEVER,     1'b0, STEP_IDLE};
			STEP_DIVD:     w = '{OP_DIV_STEP,   COND_NOT_LAST,  1'b0, STEP_DIVD};
			STEP_DEN_DONE: w = '{OP_DEN_DONE,   COND_OUT_FREE,  1'b1, STEP_IDLE};
			STEP_PASS:     w = '{OP_PASS,       COND_OUT_FREE,  1'b1, STEP_IDLE};
			STEP_SETG_Y:   w = '{OP_SETG_Y,     COND_ALWAYS,    1'b0, STEP_DIVN_IN};
			default:       w = '{OP_NOP,        COND_ALWAYS,    1'b0, STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* hdl/frd_datapath.sv */
// Datapath of the fraction reducer: GCD registers, restoring divider, result registers.
`timescale 1ns / 1ps
`default_nettype none

module frd_datapath
	import frd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire op_t                          op,
	input  wire logic                         in_valid,
	input  wire logic signed [DATA_WIDTH-1:0] num_in,
	input  wire logic signed [DATA_WIDTH-1:0] den_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0]      num_out,
	output logic signed [DATA_WIDTH-1:0]      den_out,
	output logic                              zero_den,
	output status_t                           status
);

	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

	logic [DATA_WIDTH-1:0] n_q, d_q, x_q, y_q, g_q, rem_q, quo_q, num_res_q;
	logic [DATA_WIDTH-1:0] num_out_q, den_out_q;
	logic [CNT_W-1:0]      k_q, cnt_q;
	logic                  zero_q, out_valid_q;

	logic [DATA_WIDTH-1:0] n_mag, d_mag, div_sh, quo_neg;
	logic                  div_ge, out_free;

	assign n_mag    = n_q[DATA_WIDTH-1] ? (~n_q + 1'b1) : n_q;
	assign d_mag    = d_q[DATA_WIDTH-1] ? (~d_q + 1'b1) : d_q;
	// remainder stays below g <= 2^(W-1), so the shifted value fits in W bits
	assign div_sh   = {rem_q[DATA_WIDTH-2:0], quo_q[DATA_WIDTH-1]};
	assign div_ge   = div_sh >= g_q;
	assign quo_neg  = ~quo_q + 1'b1;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		status.den_zero  = d_q == '0;
		status.num_zero  = n_q == '0;
		status.both_even = !x_q[0] && !y_q[0];
		status.x_even    = !x_q[0];
		status.y_even    = !y_q[0];
		status.x_ne_y    = x_q != y_q;
		status.div_last  = cnt_q == CNT_LAST;
		status.out_full  = out_valid_q && out_stall;
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (in_valid) begin
					n_q <= num_in;
					d_q <= den_in;
					x_q <= num_in[DATA_WIDTH-1] ? (~num_in + 1'b1) : num_in;
					y_q <= den_in[DATA_WIDTH-1] ? (~den_in + 1'b1) : den_in;
					k_q <= '0;
				end
			end
			OP_HALVE_BOTH: begin
				if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end
			end
			OP_HALVE_X: begin
				if (!x_q[0]) x_q <= x_q >> 1;
			end
			OP_HALVE_Y: begin
				if (!y_q[0]) y_q <= y_q >> 1;
			end
			OP_SUB: begin
				// both odd: keep the smaller, replace the other by the difference
				if (x_q < y_q) begin
					y_q <= y_q - x_q;
				end else begin
					x_q <= y_q;
					y_q <= x_q - y_q;
				end
			end
			OP_SETG:   g_q <= x_q << k_q;
			OP_SETG_Y: g_q <= y_q;
			OP_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= n_mag;
				cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? (div_sh - g_q) : div_sh;
				quo_q <= {quo_q[DATA_WIDTH-2:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_NUM_DONE: begin
				num_res_q <= n_q[DATA_WIDTH-1] ? quo_neg : quo_q;
				rem_q     <= '0;
				quo_q     <= d_mag;
				cnt_q     <= '0;
			end
			OP_DEN_DONE: begin
				if (out_free) begin
					num_out_q <= num_res_q;
					den_out_q <= d_q[DATA_WIDTH-1] ? quo_neg : quo_q;
					zero_q    <= 1'b0;
				end
			end
			OP_PASS: begin
				if (out_free) begin
					num_out_q <= n_q;
					den_out_q <= d_q;
					zero_q    <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((op == OP_DEN_DONE || op == OP_PASS) && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign num_out   = num_out_q;
	assign den_out   = den_out_q;
	assign zero_den  = zero_q;

	a_sub_odd: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_SUB |-> x_q[0] && y_q[0])
		else $error("subtract step reached with an even operand");

	a_rem_below_g: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_DIV_STEP |-> rem_q < g_q)
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

/* hdl/fraction_reducer_core.sv */
// Top level of the fraction reducer: microcode sequencer driving the datapath.
// Flow: a zero denominator is passed straight to the output register with zero_den set; a zero
// numerator takes g from the denominator, otherwise the binary GCD loop (halvings, then
// subtract rounds) sets g; numerator and denominator are then divided by g in turn.
// Requests: one at a time, as in_stall is high outside the idle step; the next request is
// taken at the idle step even while the previous result still waits at the output register.
// Reset: arst_n clears the step counter and the output valid; no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module fraction_reducer_core
	import frd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [DATA_WIDTH-1:0] num_in,
	input  wire logic signed [DATA_WIDTH-1:0] den_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0]      num_out,
	output logic signed [DATA_WIDTH-1:0]      den_out,
	output logic                              zero_den
);

	step_t      pc_q, pc_next;
	ctrl_word_t ctrl;
	status_t    status;
	logic       take;

	assign ctrl     = frd_rom(pc_q);
	assign in_stall = pc_q != STEP_IDLE;

	always_comb begin
		case (ctrl.cond)
			COND_NEVER:     take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_REQ:       take = in_valid;
			COND_DEN_ZERO:  take = status.den_zero;
			COND_NUM_ZERO:  take = status.num_zero;
			COND_BOTH_EVEN: take = status.both_even;
			COND_X_EVEN:    take = status.x_even;
			COND_Y_EVEN:    take = status.y_even;
			COND_X_NE_Y:    take = status.x_ne_y;
			COND_NOT_LAST:  take = !status.div_last;
			COND_OUT_FREE:  take = !status.out_full;
			default:        take = 1'b1;
		endcase
		if (take) pc_next = ctrl.target;
		else if (ctrl.hold) pc_next = pc_q;
		else pc_next = pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	frd_datapath #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (ctrl.op),
		.in_valid (in_valid),
		.num_in   (num_in),
		.den_in   (den_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.num_out  (num_out),
		.den_out  (den_out),
		.zero_den (zero_den),
		.status   (status)
	);

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= STEP_LAST)
		else $error("step counter outside the microcode table");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> pc_q == STEP_CHK_DEN)
		else $error("accepted request did not start the program");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (zero_den == (den_out == '0)))
		else $error("zero_den flag disagrees with the denominator");

endmodule

`default_nettype wire
